>>> src/pad_pkg.sv
// shared types, constants and helpers for the padding address generator
// no dependencies
package pad_pkg;

   localparam int CoordW = 18;
   localparam int DimW   = 16;
   localparam int DivW   = 17;
   localparam int DataW  = 32;
   localparam int IdxW   = 3;
   localparam int DivStages = 6;
   localparam int BitsPerStage = 3;

   localparam logic [1:0] MODE_CONSTANT  = 2'd0;
   localparam logic [1:0] MODE_REPLICATE = 2'd1;
   localparam logic [1:0] MODE_CIRCULAR  = 2'd2;
   localparam logic [1:0] MODE_REFLECT   = 2'd3;

   localparam logic [IdxW-1:0] CSR_PAD_MODE   = 3'd0;
   localparam logic [IdxW-1:0] CSR_SRC_ROWS   = 3'd1;
   localparam logic [IdxW-1:0] CSR_SRC_COLS   = 3'd2;
   localparam logic [IdxW-1:0] CSR_PAD_TOP    = 3'd3;
   localparam logic [IdxW-1:0] CSR_PAD_LEFT   = 3'd4;
   localparam logic [IdxW-1:0] CSR_ROW_STRIDE = 3'd5;
   localparam logic [IdxW-1:0] CSR_COL_STRIDE = 3'd6;
   localparam logic [IdxW-1:0] CSR_FILL_BITS  = 3'd7;

   // one axis on its way through the remainder pipeline
   typedef struct packed {
      logic              neg;
      logic              in_rng;
      logic [CoordW-1:0] mag;
      logic [DivW-1:0]   rem;
   } axis_type;

   typedef struct packed {
      logic     valid;
      logic     fill;
      axis_type row;
      axis_type col;
   } stage_type;

   // one restoring remainder step: shift in a bit, subtract if it fits
   function automatic logic [DivW-1:0] rem_step(logic [DivW-1:0] rem, logic b,
                                                logic [DivW-1:0] d);
      logic [DivW:0] t;
      logic [DivW:0] s;
      t = {rem, b};
      s = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         rem_step = s[DivW-1:0];
      end else begin
         rem_step = t[DivW-1:0];
      end
   endfunction

endpackage

>>> src/pad_source_address.sv
// top level of the padding address generator: csr bank and datapath pipeline
// depends on pad_pkg
//
// usage
//  - csr port: csr_write_en, csr_index, csr_wdata write one register per cycle,
//    no wait state; write only while no request is in flight
//  - request channel: a request (req_dst_row, req_dst_col) is taken at every
//    rising edge with start high and busy low; busy is never raised, so one
//    request per cycle is sustained
//  - result channel: rsp_valid strobes for one cycle with rsp_src_offset,
//    rsp_use_fill and rsp_fill_value; the receiver cannot stall
//  - pipeline: a request taken at a rising edge passes through ten register
//    stages before its result shows on the result channel
//  - stages: coordinate subtract and range check, six remainder stages of
//    three bits each (the modulo by size or reflect period), axis mapping,
//    stride multiply, final add
//  - reset clears all valid bits and loads the csr reset values
//  - throughput: one request per cycle, set by the fully pipelined remainder
module pad_source_address
   import pad_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CoordW-1:0] req_dst_row,
   input  logic [CoordW-1:0] req_dst_col,
   output logic              rsp_valid,
   output logic signed [DataW-1:0] rsp_src_offset,
   output logic              rsp_use_fill,
   output logic [DataW-1:0]  rsp_fill_value,
   input  logic              csr_write_en,
   input  logic [IdxW-1:0]   csr_index,
   input  logic [DataW-1:0]  csr_wdata
);

   // csr bank
   logic [1:0]       pad_mode_ff;
   logic [DimW-1:0]  src_rows_ff, src_cols_ff, pad_top_ff, pad_left_ff;
   logic [DataW-1:0] row_stride_ff, col_stride_ff, fill_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_mode_ff   <= MODE_CONSTANT;
         src_rows_ff   <= 16'd1;
         src_cols_ff   <= 16'd1;
         pad_top_ff    <= '0;
         pad_left_ff   <= '0;
         row_stride_ff <= '0;
         col_stride_ff <= 32'd1;
         fill_bits_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PAD_MODE:   pad_mode_ff   <= csr_wdata[1:0];
            CSR_SRC_ROWS:   src_rows_ff   <= csr_wdata[DimW-1:0];
            CSR_SRC_COLS:   src_cols_ff   <= csr_wdata[DimW-1:0];
            CSR_PAD_TOP:    pad_top_ff    <= csr_wdata[DimW-1:0];
            CSR_PAD_LEFT:   pad_left_ff   <= csr_wdata[DimW-1:0];
            CSR_ROW_STRIDE: row_stride_ff <= csr_wdata;
            CSR_COL_STRIDE: col_stride_ff <= csr_wdata;
            CSR_FILL_BITS:  fill_bits_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // extents (zero treated as one) and per-axis divisors
   logic [DimW-1:0] dim_row, dim_col;
   logic [DivW-1:0] div_row, div_col;
   logic            is_reflect;

   assign dim_row    = (src_rows_ff == '0) ? 16'd1 : src_rows_ff;
   assign dim_col    = (src_cols_ff == '0) ? 16'd1 : src_cols_ff;
   assign is_reflect = (pad_mode_ff == MODE_REFLECT);

   // reflect uses period 2*dim-2; size one maps through a divisor of one to 0
   always_comb begin
      div_row = {1'b0, dim_row};
      div_col = {1'b0, dim_col};
      if (is_reflect) begin
         div_row = (dim_row == 16'd1) ? 17'd1 : ({dim_row, 1'b0} - 17'd2);
         div_col = (dim_col == 16'd1) ? 17'd1 : ({dim_col, 1'b0} - 17'd2);
      end
   end

   // stage 0: subtract leading padding, range check, magnitude
   stage_type stage_ff [0:DivStages];
   stage_type stage_in [0:DivStages];

   logic [CoordW:0] r_diff, c_diff;
   logic            r_in, c_in;

   always_comb begin
      r_diff = {1'b0, req_dst_row} - {3'b0, pad_top_ff};
      c_diff = {1'b0, req_dst_col} - {3'b0, pad_left_ff};
      r_in   = !r_diff[CoordW] && (r_diff[CoordW-1:0] < {2'b0, dim_row});
      c_in   = !c_diff[CoordW] && (c_diff[CoordW-1:0] < {2'b0, dim_col});
      stage_in[0].valid      = start && !busy;
      stage_in[0].fill       = (pad_mode_ff == MODE_CONSTANT) && !(r_in && c_in);
      stage_in[0].row.neg    = r_diff[CoordW];
      stage_in[0].row.in_rng = r_in;
      stage_in[0].row.mag    = r_diff[CoordW] ? (~r_diff[CoordW-1:0] + 18'd1)
                                              : r_diff[CoordW-1:0];
      stage_in[0].row.rem    = '0;
      stage_in[0].col.neg    = c_diff[CoordW];
      stage_in[0].col.in_rng = c_in;
      stage_in[0].col.mag    = c_diff[CoordW] ? (~c_diff[CoordW-1:0] + 18'd1)
                                              : c_diff[CoordW-1:0];
      stage_in[0].col.rem    = '0;
   end

   // remainder stages, three magnitude bits each, msb first
   for (genvar k = 1; k <= DivStages; k++) begin : g_div
      localparam int Hi = CoordW - 1 - (k - 1) * BitsPerStage;
      always_comb begin
         stage_in[k] = stage_ff[k-1];
         for (int j = 0; j < BitsPerStage; j++) begin
            stage_in[k].row.rem = rem_step(stage_in[k].row.rem,
                                           stage_ff[k-1].row.mag[Hi-j], div_row);
            stage_in[k].col.rem = rem_step(stage_in[k].col.rem,
                                           stage_ff[k-1].col.mag[Hi-j], div_col);
         end
      end
   end

   for (genvar k = 0; k <= DivStages; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k].valid <= stage_in[k].valid;
         end
         stage_ff[k].fill <= stage_in[k].fill;
         stage_ff[k].row  <= stage_in[k].row;
         stage_ff[k].col  <= stage_in[k].col;
      end
   end

   // axis mapping: in range, replicate, circular, reflect; other modes map to zero
   function automatic logic [DimW-1:0] map_axis(axis_type a, logic [DimW-1:0] dim,
                                                logic [DivW-1:0] d, logic [1:0] mode);
      logic [DivW-1:0] m;
      logic [DivW-1:0] f;
      m = (a.neg && (a.rem != '0)) ? (d - a.rem) : a.rem;
      f = d - m;
      if (a.in_rng) begin
         map_axis = a.mag[DimW-1:0];
      end else begin
         case (mode)
            MODE_REPLICATE: map_axis = a.neg ? '0 : (dim - 16'd1);
            MODE_CIRCULAR:  map_axis = m[DimW-1:0];
            MODE_REFLECT:   map_axis = (m < {1'b0, dim}) ? m[DimW-1:0] : f[DimW-1:0];
            default:        map_axis = '0;
         endcase
      end
   endfunction

   logic            map_valid_ff, map_fill_ff;
   logic [DimW-1:0] map_row_ff, map_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else begin
         map_valid_ff <= stage_ff[DivStages].valid;
      end
      map_fill_ff <= stage_ff[DivStages].fill;
      map_row_ff  <= map_axis(stage_ff[DivStages].row, dim_row, div_row, pad_mode_ff);
      map_col_ff  <= map_axis(stage_ff[DivStages].col, dim_col, div_col, pad_mode_ff);
   end

   // stride products, low 32 bits only
   logic             mul_valid_ff, mul_fill_ff;
   logic [DataW-1:0] prod_row_ff, prod_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= map_valid_ff;
      end
      mul_fill_ff <= map_fill_ff;
      prod_row_ff <= DataW'({16'b0, map_row_ff} * row_stride_ff);
      prod_col_ff <= DataW'({16'b0, map_col_ff} * col_stride_ff);
   end

   // final add and output register
   logic             out_valid_ff, out_fill_ff;
   logic [DataW-1:0] out_offset_ff, out_fill_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= mul_valid_ff;
      end
      out_fill_ff     <= mul_fill_ff;
      out_offset_ff   <= mul_fill_ff ? '0 : (prod_row_ff + prod_col_ff);
      out_fill_val_ff <= mul_fill_ff ? fill_bits_ff : '0;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_src_offset = out_offset_ff;
   assign rsp_use_fill   = out_fill_ff;
   assign rsp_fill_value = out_fill_val_ff;

endmodule
